// ----- src/disc_overlap_rejection_table_macros.svh -----
// assertion macros shared by the disc overlap rejection table modules
`ifndef DISC_OVERLAP_REJECTION_TABLE_MACROS_SVH
`define DISC_OVERLAP_REJECTION_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DORT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define DORT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define DORT_ASSERT(lbl, prop, msg)
`define DORT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/dort_pkg.sv -----
// types and constants of the disc overlap rejection table
`default_nettype none
package dort_pkg;
   localparam int CAPACITY_DEFAULT = 1024;
   localparam int COORD_BITS       = 20;
   localparam int CFG_W            = 11;
   localparam int COUNT_W          = 11;
   localparam int CONF_W           = 10;
   localparam int STATUS_W         = 2;

   localparam logic [CFG_W-1:0] MAX_DISCS_RESET = CFG_W'(1000);

   localparam logic [STATUS_W-1:0] STAT_ACCEPT  = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_OVERLAP = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_CLEARED = 2'd3;

   localparam logic KIND_CLEAR = 1'b0;

   typedef struct packed {
      logic                  kind;
      logic [COORD_BITS-1:0] cand_x;
      logic [COORD_BITS-1:0] cand_y;
      logic [COORD_BITS-1:0] cand_diam;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  placed_count;
      logic [CONF_W-1:0]   conflict_index;
   } rsp_type;

   // control that travels with each stored entry into the compare pipeline
   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic hit;
   } res_type;
endpackage
`default_nettype wire

// ----- src/dort_chan_if.sv -----
// valid/ready channel carrying one payload per transfer
`default_nettype none
interface dort_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- src/dort_cmp.sv -----
// pipelined overlap test of the candidate against one stored disc per cycle
`default_nettype none
`include "disc_overlap_rejection_table_macros.svh"
module dort_cmp #(
   parameter int CAPACITY = dort_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                flush,
   input  logic [dort_pkg::COORD_BITS-1:0]     cand_x,
   input  logic [dort_pkg::COORD_BITS-1:0]     cand_y,
   input  logic [dort_pkg::COORD_BITS-1:0]     cand_d,
   input  logic [dort_pkg::COORD_BITS-1:0]     ent_x,
   input  logic [dort_pkg::COORD_BITS-1:0]     ent_y,
   input  logic [dort_pkg::COORD_BITS-1:0]     ent_d,
   input  dort_pkg::ctl_type                   ctl_in,
   input  logic [$clog2(CAPACITY)-1:0]         idx_in,
   output dort_pkg::res_type                   res_out,
   output logic [$clog2(CAPACITY)-1:0]         idx_out
);
   localparam int C     = dort_pkg::COORD_BITS;
   localparam int IDX_W = $clog2(CAPACITY);

   dort_pkg::ctl_type s1_ctl_ff, s2_ctl_ff;
   dort_pkg::res_type res_ff;
   logic [IDX_W-1:0]  s1_idx_ff, s2_idx_ff, idx_out_ff;
   logic [C-1:0]      dx_ff, dy_ff;
   logic [C:0]        sd_ff;
   logic [2*C-1:0]    dx2_ff, dy2_ff;
   logic [2*C+1:0]    sd2_ff;
   logic [2*C:0]      dist_sum;
   logic [2*C+2:0]    lhs;
   logic              hit;

   // 4*(dx^2 + dy^2) < (d + D)^2
   assign dist_sum = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign lhs      = {dist_sum, 2'b00};
   assign hit      = lhs < {1'b0, sd2_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         res_ff    <= '0;
      end else begin
         s1_ctl_ff.valid <= ctl_in.valid && !flush;
         s1_ctl_ff.last  <= ctl_in.last;
         s2_ctl_ff.valid <= s1_ctl_ff.valid && !flush;
         s2_ctl_ff.last  <= s1_ctl_ff.last;
         res_ff.valid    <= s2_ctl_ff.valid && !flush;
         res_ff.last     <= s2_ctl_ff.last;
         res_ff.hit      <= hit;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff      <= (cand_x >= ent_x) ? (cand_x - ent_x) : (ent_x - cand_x);
      dy_ff      <= (cand_y >= ent_y) ? (cand_y - ent_y) : (ent_y - cand_y);
      sd_ff      <= {1'b0, cand_d} + {1'b0, ent_d};
      s1_idx_ff  <= idx_in;
      dx2_ff     <= dx_ff * dx_ff;
      dy2_ff     <= dy_ff * dy_ff;
      sd2_ff     <= sd_ff * sd_ff;
      s2_idx_ff  <= s1_idx_ff;
      idx_out_ff <= s2_idx_ff;
   end

   assign res_out = res_ff;
   assign idx_out = idx_out_ff;

   `DORT_ASSERT_NEXT(a_flush_empties, flush, !s1_ctl_ff.valid && !s2_ctl_ff.valid && !res_ff.valid, "compare pipeline not emptied by flush")
   `DORT_ASSERT(a_res_from_input, res_ff.valid |-> $past(ctl_in.valid, 3), "compare result without a matching read")
   `DORT_ASSERT(a_idx_follows, res_ff.valid |-> (idx_out_ff == $past(idx_in, 3)), "compare result index out of step")
endmodule
`default_nettype wire

// ----- src/disc_overlap_rejection_table.sv -----
// top level of the disc overlap rejection table
`default_nettype none
`include "disc_overlap_rejection_table_macros.svh"
// Keeps up to CAPACITY discs (x, y, diameter) in one single-port-style synchronous
// memory and checks each candidate against them in store order, one stored disc
// read per cycle into the compare pipeline; the first overlap found wins and the
// scan stops. A candidate is checked against every placed disc unless an early
// disc overlaps; an offer into an empty table skips the scan, and a clear goes
// straight to its result. A finished result sits in an output register, so the
// next item can be taken before the result is. The limit written through
// csr_wr_data is held to 1..CAPACITY when used.
module disc_overlap_rejection_table #(
   parameter int CAPACITY = dort_pkg::CAPACITY_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   dort_chan_if.sink                    req_chan,
   dort_chan_if.source                  rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [dort_pkg::CFG_W-1:0]   csr_wr_data
);
   localparam int C     = dort_pkg::COORD_BITS;
   localparam int ENT_W = 3 * C;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE, S_DONE} state_type;

   state_type                    state_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [CNT_W-1:0]             iss_ff;
   logic [CNT_W-1:0]             lim;
   logic [dort_pkg::CFG_W-1:0]   max_ff;
   logic [C-1:0]                 cand_x_ff, cand_y_ff, cand_d_ff;
   logic [dort_pkg::STATUS_W-1:0] res_status_ff;
   logic [IDX_W-1:0]             res_conf_ff;
   logic                         rsp_vld_ff;
   dort_pkg::rsp_type            rsp_data_ff;

   logic [ENT_W-1:0]             disc_mem [CAPACITY];
   logic [ENT_W-1:0]             rd_data_ff;
   dort_pkg::ctl_type            rd_ctl_ff;
   logic [IDX_W-1:0]             rd_idx_ff;

   dort_pkg::res_type            cmp_res;
   logic [IDX_W-1:0]             cmp_idx;

   logic accept, rd_en, mem_wr, flush, iss_last, rsp_load;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign flush    = (state_ff == S_SCAN) && cmp_res.valid && cmp_res.hit;
   assign rd_en    = (state_ff == S_SCAN) && (iss_ff < cnt_ff) && !flush;
   assign iss_last = (iss_ff == (cnt_ff - CNT_W'(1)));
   assign mem_wr   = (state_ff == S_DECIDE) && (cnt_ff < lim);
   assign rsp_load = (state_ff == S_DONE) && (!rsp_vld_ff || rsp_chan.ready);

   // effective limit held to 1..CAPACITY
   always_comb begin
      if (max_ff == '0) begin
         lim = CNT_W'(1);
      end else if (32'(max_ff) > 32'(CAPACITY)) begin
         lim = CNT_W'(CAPACITY);
      end else begin
         lim = CNT_W'(max_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= dort_pkg::MAX_DISCS_RESET;
      end else if (csr_wr_en) begin
         max_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         disc_mem[cnt_ff[IDX_W-1:0]] <= {cand_x_ff, cand_y_ff, cand_d_ff};
      end
      if (rd_en) begin
         rd_data_ff <= disc_mem[iss_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ctl_ff <= '0;
      end else begin
         rd_ctl_ff.valid <= rd_en;
         rd_ctl_ff.last  <= iss_last;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= iss_ff[IDX_W-1:0];
   end

   dort_cmp #(
      .CAPACITY (CAPACITY)
   ) u_cmp (
      .clock   (clock),
      .reset   (reset),
      .flush   (flush),
      .cand_x  (cand_x_ff),
      .cand_y  (cand_y_ff),
      .cand_d  (cand_d_ff),
      .ent_x   (rd_data_ff[ENT_W-1 -: C]),
      .ent_y   (rd_data_ff[2*C-1 -: C]),
      .ent_d   (rd_data_ff[C-1:0]),
      .ctl_in  (rd_ctl_ff),
      .idx_in  (rd_idx_ff),
      .res_out (cmp_res),
      .idx_out (cmp_idx)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_vld_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cand_x_ff <= req_chan.payload.cand_x;
                  cand_y_ff <= req_chan.payload.cand_y;
                  cand_d_ff <= req_chan.payload.cand_diam;
                  iss_ff    <= '0;
                  priority if (req_chan.payload.kind == dort_pkg::KIND_CLEAR) begin
                     cnt_ff        <= '0;
                     res_status_ff <= dort_pkg::STAT_CLEARED;
                     res_conf_ff   <= '0;
                     state_ff      <= S_DONE;
                  end else if (cnt_ff == '0) begin
                     state_ff <= S_DECIDE;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (rd_en) begin
                  iss_ff <= iss_ff + CNT_W'(1);
               end
               priority if (flush) begin
                  res_status_ff <= dort_pkg::STAT_OVERLAP;
                  res_conf_ff   <= cmp_idx;
                  state_ff      <= S_DONE;
               end else if (cmp_res.valid && cmp_res.last) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               res_conf_ff <= '0;
               if (cnt_ff < lim) begin
                  res_status_ff <= dort_pkg::STAT_ACCEPT;
                  cnt_ff        <= cnt_ff + CNT_W'(1);
               end else begin
                  res_status_ff <= dort_pkg::STAT_FULL;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_data_ff.status          <= res_status_ff;
                  rsp_data_ff.placed_count    <= dort_pkg::COUNT_W'(cnt_ff);
                  rsp_data_ff.conflict_index  <= dort_pkg::CONF_W'(res_conf_ff);
                  state_ff                    <= S_IDLE;
               end
            end
         endcase
      end
   end

   `DORT_ASSERT(a_res_in_scan, cmp_res.valid |-> (state_ff == S_SCAN), "compare result outside a scan")
   `DORT_ASSERT_NEXT(a_append, mem_wr, cnt_ff == ($past(cnt_ff) + CNT_W'(1)), "append did not advance the count")
   `DORT_ASSERT_NEXT(a_clear, accept && (req_chan.payload.kind == dort_pkg::KIND_CLEAR), cnt_ff == '0, "clear left discs in the table")
endmodule
`default_nettype wire
